FILE: src/y420rgb_pkg.sv
package y420rgb_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_COEF_LUMA     = 3'd0;
  localparam logic [2:0] REG_COEF_CR_RED   = 3'd1;
  localparam logic [2:0] REG_COEF_CR_GREEN = 3'd2;
  localparam logic [2:0] REG_COEF_CB_GREEN = 3'd3;
  localparam logic [2:0] REG_COEF_CB_BLUE  = 3'd4;
  localparam logic [2:0] REG_FRAC_SHIFT    = 3'd5;
  localparam logic [2:0] REG_UPSAMPLE_MODE = 3'd6;

  // chroma upsampling modes
  localparam logic [1:0] MODE_ZERO_FILL = 2'd0;
  localparam logic [1:0] MODE_REPLICATE = 2'd1;
  localparam logic [1:0] MODE_AVERAGE   = 2'd2;

  // pixel positions within a block, raster order
  localparam logic [1:0] PIX_TOP_LEFT     = 2'd0;
  localparam logic [1:0] PIX_TOP_RIGHT    = 2'd1;
  localparam logic [1:0] PIX_BOTTOM_LEFT  = 2'd2;
  localparam logic [1:0] PIX_BOTTOM_RIGHT = 2'd3;

  // reset values of the configuration registers
  localparam logic [14:0] RST_COEF_LUMA     = 15'd9535;
  localparam logic [14:0] RST_COEF_CR_RED   = 15'd13074;
  localparam logic [14:0] RST_COEF_CR_GREEN = 15'd6660;
  localparam logic [14:0] RST_COEF_CB_GREEN = 15'd3203;
  localparam logic [14:0] RST_COEF_CB_BLUE  = 15'd16531;
  localparam logic [3:0]  RST_FRAC_SHIFT    = 4'd13;
  localparam logic [1:0]  RST_UPSAMPLE_MODE = 2'd1;

  localparam int CFG_DATA_W = 15;

  typedef struct packed {
    logic [7:0] y_top_left;
    logic [7:0] y_top_right;
    logic [7:0] y_bottom_left;
    logic [7:0] y_bottom_right;
    logic [7:0] cb_here;
    logic [7:0] cb_right;
    logic [7:0] cb_below;
    logic [7:0] cb_diagonal;
    logic [7:0] cr_here;
    logic [7:0] cr_right;
    logic [7:0] cr_below;
    logic [7:0] cr_diagonal;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_item_t;

endpackage

FILE: src/ycbcr420_to_rgb_converter.sv
// ycbcr 4:2:0 to rgb converter, one 2x2 luma block per input transaction
//
// input channel (in_valid/in_ready/in_data): four luma samples of a block plus
// the block's own cb/cr and those of its right, lower and diagonal neighbours.
// output channel (out_valid/out_ready/out_data): four pixel transactions per
// block in raster order (top-left, top-right, bottom-left, bottom-right), the
// last one carrying last_pixel.
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready, one
// register write per transaction; write only while the block is idle.
//
// the first pixel of a block passes through the block register and then the
// result register; the rest follow one per cycle unless the receiver stalls.
// throughput: one pixel per cycle unless the receiver stalls; the single
// pixel datapath (five coefficient multipliers, rounding shift, clamp) sets this.
// the next block is taken in the same cycle its last pixel is computed.
//
// reset: coefficient registers return to their bt.601 defaults, the block and
// output registers are emptied. a stalled receiver holds the output register,
// which in turn stops the pixel counter and then the input channel.
module ycbcr420_to_rgb_converter
  import y420rgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef logic signed [25:0] acc_t;

  // configuration registers
  logic [14:0] coef_luma_r, coef_cr_red_r, coef_cr_green_r, coef_cb_green_r, coef_cb_blue_r;
  logic [3:0]  frac_shift_r;
  logic [1:0]  upsample_mode_r;

  // block register and pixel sequencing
  in_item_t    blk_r;
  logic        blk_vld_r;
  logic [1:0]  pix_cnt_r;

  // result register
  out_item_t   out_r;
  logic        out_vld_r;

  logic        advance;
  logic        blk_done;
  logic        in_fire;

  assign cfg_ready = 1'b1;

  // a pixel moves into the result register when it is free or being emptied
  assign advance  = blk_vld_r && (!out_vld_r || out_ready);
  assign blk_done = advance && (pix_cnt_r == PIX_BOTTOM_RIGHT);
  assign in_ready = !blk_vld_r || blk_done;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_luma_r     <= RST_COEF_LUMA;
      coef_cr_red_r   <= RST_COEF_CR_RED;
      coef_cr_green_r <= RST_COEF_CR_GREEN;
      coef_cb_green_r <= RST_COEF_CB_GREEN;
      coef_cb_blue_r  <= RST_COEF_CB_BLUE;
      frac_shift_r    <= RST_FRAC_SHIFT;
      upsample_mode_r <= RST_UPSAMPLE_MODE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COEF_LUMA:     coef_luma_r     <= cfg_data;
        REG_COEF_CR_RED:   coef_cr_red_r   <= cfg_data;
        REG_COEF_CR_GREEN: coef_cr_green_r <= cfg_data;
        REG_COEF_CB_GREEN: coef_cb_green_r <= cfg_data;
        REG_COEF_CB_BLUE:  coef_cb_blue_r  <= cfg_data;
        REG_FRAC_SHIFT:    frac_shift_r    <= cfg_data[3:0];
        REG_UPSAMPLE_MODE: upsample_mode_r <= cfg_data[1:0];
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  // chroma for one pixel position from the four neighbouring samples
  function automatic logic [7:0] upsample(input logic [1:0] mode, input logic [1:0] pix,
                                          input logic [7:0] h, input logic [7:0] rt,
                                          input logic [7:0] bl, input logic [7:0] dg);
    logic [8:0] sum_rt;
    logic [8:0] sum_bl;
    logic [9:0] sum_all;
    logic [7:0] c;
    sum_rt  = {1'b0, h} + {1'b0, rt} + 9'd1;
    sum_bl  = {1'b0, h} + {1'b0, bl} + 9'd1;
    sum_all = {2'b0, h} + {2'b0, rt} + {2'b0, bl} + {2'b0, dg} + 10'd2;
    c = h;
    if (pix != PIX_TOP_LEFT) begin
      unique case (mode)
        MODE_ZERO_FILL: c = 8'd0;
        MODE_AVERAGE: begin
          unique case (pix)
            PIX_TOP_RIGHT:   c = sum_rt[8:1];
            PIX_BOTTOM_LEFT: c = sum_bl[8:1];
            default:         c = sum_all[9:2];
          endcase
        end
        default: c = h; // replicate, and the unused code
      endcase
    end
    return c;
  endfunction

  // rounding arithmetic shift then clamp to 0..255
  function automatic logic [7:0] round_clamp(input acc_t acc, input logic [3:0] k);
    acc_t rnd;
    acc_t sh;
    logic [7:0] v;
    if (k == 4'd0) begin
      sh = acc;
    end else begin
      rnd = acc_t'(1) <<< (k - 4'd1);
      sh  = (acc + rnd) >>> k;
    end
    if (sh < 0) v = 8'd0;
    else if (sh > acc_t'(255)) v = 8'd255;
    else v = sh[7:0];
    return v;
  endfunction

  // single pixel datapath, pixel picked by the counter
  logic [7:0]        y_sel, cb_sel, cr_sel;
  logic signed [8:0] yy, cbb, crr;
  acc_t              p_luma, p_cr_red, p_cr_green, p_cb_green, p_cb_blue;
  acc_t              acc_r_c, acc_g_c, acc_b_c;
  out_item_t         pix_c;

  always_comb begin
    unique case (pix_cnt_r)
      PIX_TOP_LEFT:    y_sel = blk_r.y_top_left;
      PIX_TOP_RIGHT:   y_sel = blk_r.y_top_right;
      PIX_BOTTOM_LEFT: y_sel = blk_r.y_bottom_left;
      default:         y_sel = blk_r.y_bottom_right;
    endcase
    cb_sel = upsample(upsample_mode_r, pix_cnt_r, blk_r.cb_here, blk_r.cb_right,
                      blk_r.cb_below, blk_r.cb_diagonal);
    cr_sel = upsample(upsample_mode_r, pix_cnt_r, blk_r.cr_here, blk_r.cr_right,
                      blk_r.cr_below, blk_r.cr_diagonal);

    // offset removal
    yy  = $signed({1'b0, y_sel})  - 9'sd16;
    cbb = $signed({1'b0, cb_sel}) - 9'sd128;
    crr = $signed({1'b0, cr_sel}) - 9'sd128;

    // 16x9 signed products, 25 bits, carried at 26
    p_luma     = acc_t'($signed({1'b0, coef_luma_r}))     * acc_t'(yy);
    p_cr_red   = acc_t'($signed({1'b0, coef_cr_red_r}))   * acc_t'(crr);
    p_cr_green = acc_t'($signed({1'b0, coef_cr_green_r})) * acc_t'(crr);
    p_cb_green = acc_t'($signed({1'b0, coef_cb_green_r})) * acc_t'(cbb);
    p_cb_blue  = acc_t'($signed({1'b0, coef_cb_blue_r}))  * acc_t'(cbb);

    acc_r_c = p_luma + p_cr_red;
    acc_g_c = p_luma - p_cr_green - p_cb_green;
    acc_b_c = p_luma + p_cb_blue;

    pix_c.red        = round_clamp(acc_r_c, frac_shift_r);
    pix_c.green      = round_clamp(acc_g_c, frac_shift_r);
    pix_c.blue       = round_clamp(acc_b_c, frac_shift_r);
    pix_c.last_pixel = (pix_cnt_r == PIX_BOTTOM_RIGHT);
  end

  // block register: loaded on input transaction, emptied after its last pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_vld_r <= 1'b0;
      pix_cnt_r <= PIX_TOP_LEFT;
    end else begin
      if (in_fire) begin
        blk_vld_r <= 1'b1;
      end else if (blk_done) begin
        blk_vld_r <= 1'b0;
      end
      if (advance) begin
        pix_cnt_r <= pix_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      blk_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= pix_c;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: verif/tb_ycbcr420_to_rgb_converter.sv
`timescale 1ns / 1ps

module tb_ycbcr420_to_rgb_converter;
  import y420rgb_pkg::*;

  // mode value three has no name in the package; it acts as replicate
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // index seven selects no register, a write there must change nothing
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam int SETTLE_CYCLES = 6;       // margin past the output latency
  localparam int CYCLE_LIMIT   = 200000;  // far beyond the slowest legal run
  localparam int HOLD_CYCLES   = 80;      // long receiver hold-off, fills the block
  localparam int N_DIRECTED    = 19;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_EVERY_THIRD} rx_style_e;

  // one directed row: upsampling mode to run it in, the block, and for the
  // trivially readable cases a flat grey level that all four pixels must show
  typedef struct {
    logic [1:0] mode;
    in_item_t   blk;
    bit         typed;
    logic [7:0] level;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // mirror of the block's configuration registers
  logic [14:0] g_luma;
  logic [14:0] g_cr_red;
  logic [14:0] g_cr_green;
  logic [14:0] g_cb_green;
  logic [14:0] g_cb_blue;
  logic [3:0]  frac_k;
  logic [1:0]  up_mode;

  out_item_t pending_pixels [$];  // pixels still owed by the block, oldest first
  out_item_t want_px;
  out_item_t typed_px;
  int        errors;
  int        cycles;
  int        burst_left;
  int        hold_len;
  rx_style_e rx_style;
  int        rx_left;
  int        rx_tick;

  stim_row_t stim_tab [N_DIRECTED] = '{
    // reset settings: flat grey cases readable straight off the matrix
    '{MODE_REPLICATE, 96'hFFFFFFFF_80808080_80808080, 1'b1, 8'd255},
    '{MODE_REPLICATE, 96'h00000000_80808080_80808080, 1'b1, 8'd0},
    '{MODE_REPLICATE, 96'h10101010_80808080_80808080, 1'b1, 8'd0},
    // chroma extremes, saturation both ways
    '{MODE_REPLICATE, 96'hFFFFFFFF_00000000_00000000, 1'b0, 8'd0},
    '{MODE_REPLICATE, 96'hFFFFFFFF_FFFFFFFF_FFFFFFFF, 1'b0, 8'd0},
    '{MODE_REPLICATE, 96'h00000000_FFFFFFFF_00000000, 1'b0, 8'd0},
    // neighbours differ but replicate must ignore them
    '{MODE_REPLICATE, 96'h00FF10EB_F0000FFF_0FFF00F0, 1'b0, 8'd0},
    // zero fill: three pixels see chroma 0, not 128
    '{MODE_ZERO_FILL, 96'hFFFFFFFF_FF123456_FF654321, 1'b0, 8'd0},
    '{MODE_ZERO_FILL, 96'h00000000_00FFFFFF_00FFFFFF, 1'b0, 8'd0},
    '{MODE_ZERO_FILL, 96'h80808080_80808080_80808080, 1'b0, 8'd0},
    // averaging: full-scale sums, rounding of odd sums, mixed neighbours
    '{MODE_AVERAGE,   96'hFFFFFFFF_FFFFFFFF_FFFFFFFF, 1'b0, 8'd0},
    '{MODE_AVERAGE,   96'h00000000_00000000_00000000, 1'b0, 8'd0},
    '{MODE_AVERAGE,   96'h80808080_01000000_00010000, 1'b0, 8'd0},
    '{MODE_AVERAGE,   96'h10EB10EB_FF000000_00FFFFFF, 1'b0, 8'd0},
    '{MODE_AVERAGE,   96'h7F80817E_FEFF01FF_01020304, 1'b0, 8'd0},
    '{MODE_AVERAGE,   96'h55AA55AA_AA55AA55_55AA55AA, 1'b0, 8'd0},
    // unused mode value behaves as replicate
    '{MODE_SPARE,     96'hFFFFFFFF_40C01020_C0403010, 1'b0, 8'd0},
    '{MODE_SPARE,     96'h00FF00FF_FF000000_00FFFFFF, 1'b0, 8'd0},
    '{MODE_REPLICATE, 96'h12345678_9ABCDEF0_0FEDCBA9, 1'b0, 8'd0}
  };

  ycbcr420_to_rgb_converter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // chroma seen by one pixel position after upsampling
  function automatic logic [7:0] upsample_at(input logic [7:0] h, rt, bl, dg,
                                             input logic [1:0] pos);
    if (pos == PIX_TOP_LEFT) return h;
    case (up_mode)
      MODE_ZERO_FILL: return 8'd0;
      MODE_AVERAGE: begin
        case (pos)
          PIX_TOP_RIGHT:   return 8'((10'(h) + 10'(rt) + 10'd1) >> 1);
          PIX_BOTTOM_LEFT: return 8'((10'(h) + 10'(bl) + 10'd1) >> 1);
          default:         return 8'((10'(h) + 10'(rt) + 10'(bl) + 10'(dg) + 10'd2) >> 2);
        endcase
      end
      default: return h;  // replicate and the spare code
    endcase
  endfunction

  // rounding add, arithmetic shift (floor for negatives), clamp to a byte
  function automatic logic [7:0] rgb_level(input longint acc);
    if (frac_k != 4'd0)
      acc = (acc + (longint'(1) <<< (frac_k - 4'd1))) >>> frac_k;
    if (acc < 0) return 8'd0;
    if (acc > 255) return 8'd255;
    return acc[7:0];
  endfunction

  // four pixels of one block, raster order, appended to the pending queue
  function automatic void convert_block(input in_item_t b);
    logic [7:0] ys [4];
    logic [1:0] pos;
    longint     yy, cbv, crv, luma;
    out_item_t  px;
    ys = '{b.y_top_left, b.y_top_right, b.y_bottom_left, b.y_bottom_right};
    for (int p = 0; p < 4; p++) begin
      pos  = p[1:0];
      yy   = longint'(ys[p]) - 16;
      cbv  = longint'(upsample_at(b.cb_here, b.cb_right, b.cb_below, b.cb_diagonal, pos))
             - 128;
      crv  = longint'(upsample_at(b.cr_here, b.cr_right, b.cr_below, b.cr_diagonal, pos))
             - 128;
      luma = longint'(g_luma) * yy;
      px.red   = rgb_level(luma + longint'(g_cr_red) * crv);
      px.green = rgb_level(luma - longint'(g_cr_green) * crv - longint'(g_cb_green) * cbv);
      px.blue  = rgb_level(luma + longint'(g_cb_blue) * cbv);
      px.last_pixel = (pos == PIX_BOTTOM_RIGHT);
      pending_pixels.push_back(px);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // bytes lean towards the interesting values: rails, black level, zero chroma
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd16;
      3:       return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t rand_blk();
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte(),
            rand_byte(), rand_byte(), rand_byte(), rand_byte(),
            rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  // offers one block and returns at the edge where it was taken
  task automatic accept_block(input in_item_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // bursts of random length separated by random gaps
  task automatic pace(input bit gaps_on);
    burst_left--;
    if (gaps_on && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
  endtask

  // sender stops until every owed pixel has come out, then lets the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller lowers cfg_valid after its last write
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_COEF_LUMA:     g_luma     = val[14:0];
      REG_COEF_CR_RED:   g_cr_red   = val[14:0];
      REG_COEF_CR_GREEN: g_cr_green = val[14:0];
      REG_COEF_CB_GREEN: g_cb_green = val[14:0];
      REG_COEF_CB_BLUE:  g_cb_blue  = val[14:0];
      REG_FRAC_SHIFT:    frac_k     = val[3:0];
      REG_UPSAMPLE_MODE: up_mode    = val[1:0];
      default: ;
    endcase
  endtask

  // whole register set; narrow registers get junk in their unused upper bits
  task automatic set_config(input logic [14:0] lg, cr_r, cr_g, cb_g, cb_b,
                            input logic [3:0] k, input logic [1:0] m);
    write_reg(REG_COEF_LUMA, lg);
    write_reg(REG_COEF_CR_RED, cr_r);
    write_reg(REG_COEF_CR_GREEN, cr_g);
    write_reg(REG_COEF_CB_GREEN, cb_g);
    write_reg(REG_COEF_CB_BLUE, cb_b);
    write_reg(REG_FRAC_SHIFT, {11'($urandom), k});
    write_reg(REG_UPSAMPLE_MODE, {13'($urandom), m});
    write_reg(REG_NONE, 15'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic feed(input int n, input bit gaps_on);
    in_item_t b;
    for (int i = 0; i < n; i++) begin
      b = rand_blk();
      accept_block(b);
      convert_block(b);
      pace(gaps_on);
    end
  endtask

  // idle the block, load a setting, optionally start a receiver hold-off, run
  task automatic run_phase(input logic [14:0] lg, cr_r, cr_g, cb_g, cb_b,
                           input logic [3:0] k, input logic [1:0] m,
                           input int n, input bit gaps_on, input int hold);
    drain();
    set_config(lg, cr_r, cr_g, cb_g, cb_b, k, m);
    hold_len = hold;
    feed(n, gaps_on);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: its own stall pattern, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    rx_style  = RX_OPEN;
    rx_left   = 0;
    rx_tick   = 0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        // keep the output blocked while the sender keeps pushing
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      if (rx_left == 0) begin
        rx_style = rx_style_e'($urandom_range(0, 3));
        rx_left  = $urandom_range(8, 64);
      end
      rx_left--;
      rx_tick++;
      case (rx_style)
        RX_OPEN:        out_ready <= 1'b1;
        RX_MOSTLY:      out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:      out_ready <= ($urandom_range(0, 3) == 0);
        RX_EVERY_THIRD: out_ready <= (rx_tick % 3 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pixel checker: every transaction against the oldest owed pixel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel with nothing owed: red %0d green %0d blue %0d last %0b",
               out_data.red, out_data.green, out_data.blue, out_data.last_pixel);
        errors++;
      end else begin
        want_px = pending_pixels.pop_front();
        if (out_data.red !== want_px.red) begin
          $error("red: expected %0d, got %0d", want_px.red, out_data.red);
          errors++;
        end
        if (out_data.green !== want_px.green) begin
          $error("green: expected %0d, got %0d", want_px.green, out_data.green);
          errors++;
        end
        if (out_data.blue !== want_px.blue) begin
          $error("blue: expected %0d, got %0d", want_px.blue, out_data.blue);
          errors++;
        end
        if (out_data.last_pixel !== want_px.last_pixel) begin
          $error("last_pixel: expected %0b, got %0b", want_px.last_pixel,
                 out_data.last_pixel);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_COEF_LUMA;
    cfg_data   = '0;
    errors     = 0;
    cycles     = 0;
    hold_len   = 0;
    burst_left = $urandom_range(1, 8);
    // mirror starts from the reset defaults
    g_luma     = RST_COEF_LUMA;
    g_cr_red   = RST_COEF_CR_RED;
    g_cr_green = RST_COEF_CR_GREEN;
    g_cb_green = RST_COEF_CB_GREEN;
    g_cb_blue  = RST_COEF_CB_BLUE;
    frac_k     = RST_FRAC_SHIFT;
    up_mode    = RST_UPSAMPLE_MODE;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; the mode changes only once the block has gone idle
    foreach (stim_tab[i]) begin
      if (stim_tab[i].mode != up_mode) begin
        drain();
        write_reg(REG_UPSAMPLE_MODE, {13'($urandom), stim_tab[i].mode});
        cfg_valid <= 1'b0;
      end
      accept_block(stim_tab[i].blk);
      if (stim_tab[i].typed) begin
        for (int p = 0; p < 4; p++) begin
          typed_px.red        = stim_tab[i].level;
          typed_px.green      = stim_tab[i].level;
          typed_px.blue       = stim_tab[i].level;
          typed_px.last_pixel = (p == 3);
          pending_pixels.push_back(typed_px);
        end
      end else begin
        convert_block(stim_tab[i].blk);
      end
      pace(1'b1);
    end

    // bt.601 defaults written back explicitly, back-to-back blocks
    run_phase(RST_COEF_LUMA, RST_COEF_CR_RED, RST_COEF_CR_GREEN, RST_COEF_CB_GREEN,
              RST_COEF_CB_BLUE, RST_FRAC_SHIFT, RST_UPSAMPLE_MODE, 20, 1'b0, 0);
    // top of every coefficient and shift range
    run_phase('1, '1, '1, '1, '1, 4'd15, MODE_AVERAGE, 15, 1'b0, 0);
    // bottom of every coefficient range, smallest nonzero shift
    run_phase('0, '0, '0, '0, '0, 4'd1, MODE_ZERO_FILL, 10, 1'b1, 0);
    // no fraction bits: no rounding add, no shift
    run_phase(15'($urandom_range(0, 3)), 15'($urandom_range(0, 3)),
              15'($urandom_range(0, 3)), 15'($urandom_range(0, 3)),
              15'($urandom_range(0, 3)), 4'd0, MODE_SPARE, 10, 1'b1, 0);

    // random settings; the first runs under a long receiver hold-off with
    // the sender flat out, the second pauses halfway until all pixels are out
    for (int ph = 0; ph < 4; ph++) begin
      run_phase(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                15'($urandom), 4'($urandom_range(1, 15)), 2'($urandom_range(0, 3)),
                (ph == 3) ? 10 : 12, ph != 0, (ph == 0) ? HOLD_CYCLES : 0);
      if (ph == 1) begin
        drain();
        feed(10, 1'b1);
      end
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
